/* rtl/core/oaht_pkg.sv */
`timescale 1ns / 1ps

package oaht_pkg;

    // default sizing of the table
    localparam int TABLE_SHIFT_DEF = 10;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int PROBE_SHIFT_DEF = 5;

    // field and register widths
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int TAG_W       = 2;
    localparam int SHIFT_CFG_W = 4;
    localparam int LIMIT_CFG_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // actions
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

    // slot tags
    localparam logic [TAG_W-1:0] TAG_UNUSED  = 2'd0;
    localparam logic [TAG_W-1:0] TAG_DELETED = 2'd1;
    localparam logic [TAG_W-1:0] TAG_VALID   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RESIZE    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SHIFT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SHIFT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITEM_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [SHIFT_CFG_W-1:0] TABLE_SHIFT_RST = 4'd10;
    localparam logic [SHIFT_CFG_W-1:0] MIN_SHIFT_RST   = 4'd2;
    localparam logic [LIMIT_CFG_W-1:0] ITEM_LIMIT_RST  = 11'd0;

endpackage

/* rtl/core/oaht_ram.sv */
`timescale 1ns / 1ps

module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/open_address_hash_table_core.sv */
`timescale 1ns / 1ps

// Open-addressing key/value table with integer keys. Every slot (tag, key, value) lives in one
// single-port-read RAM word; an action walks the probe chain one slot per clock, since the
// RAM read of the next probe address is issued in the same cycle that the previous word is
// checked. A walk probes from 1 up to 2^shift + ceil(KEY_WIDTH/PROBE_SHIFT) slots; an action
// refused by the item limit, grow or shrink test, or an unknown action, skips the walk and goes
// straight to its result. Clear walks the whole RAM. After reset a clearing pass over every slot
// runs with s_ready low; configuration writes are taken at any time (cfg_ready is always high)
// but are meant to be issued only while the table is idle. The result waits in an output
// register, so a new item is accepted while the last result is still pending on m_valid.

module open_address_hash_table_core #(
    parameter int TABLE_SHIFT = oaht_pkg::TABLE_SHIFT_DEF,
    parameter int KEY_WIDTH   = oaht_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = oaht_pkg::VALUE_WIDTH_DEF,
    parameter int PROBE_SHIFT = oaht_pkg::PROBE_SHIFT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [oaht_pkg::ACTION_W-1:0]     s_action,
    input  logic [KEY_WIDTH-1:0]              s_key,
    input  logic [VALUE_WIDTH-1:0]            s_operand_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [oaht_pkg::STATUS_W-1:0]     m_status,
    output logic [VALUE_WIDTH-1:0]            m_value_out,
    output logic [TABLE_SHIFT-1:0]            m_found_slot,
    output logic [TABLE_SHIFT:0]              m_live_count,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [oaht_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [oaht_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import oaht_pkg::*;

    localparam int DEPTH         = 1 << TABLE_SHIFT;
    localparam int IDX_W         = TABLE_SHIFT;
    localparam int CNT_W         = TABLE_SHIFT + 1;
    localparam int PERTURB_STEPS = (KEY_WIDTH + PROBE_SHIFT - 1) / PROBE_SHIFT;
    localparam int PROBE_W       = $clog2(DEPTH + PERTURB_STEPS + 1);
    localparam int SHIFT_W       = ($clog2(TABLE_SHIFT + 1) > SHIFT_CFG_W) ?
                                   $clog2(TABLE_SHIFT + 1) : SHIFT_CFG_W;
    localparam int GROW_W        = CNT_W + 2;
    localparam int LIM_CMP_W     = (CNT_W > LIMIT_CFG_W) ? CNT_W : LIMIT_CFG_W;
    localparam int WORD_W        = TAG_W + KEY_WIDTH + VALUE_WIDTH;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    // control and counters
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        sweep_reg, sweep_next;
    logic                    sweep_report_reg, sweep_report_next;
    logic [CNT_W-1:0]        used_reg, used_next;
    logic [CNT_W-1:0]        del_reg, del_next;
    logic [PROBE_W-1:0]      probe_cnt_reg, probe_cnt_next;
    logic [PROBE_W-1:0]      limit_reg, limit_next;
    logic                    m_valid_reg, m_valid_next;

    // configuration
    logic [SHIFT_CFG_W-1:0]  tbl_shift_reg, tbl_shift_next;
    logic [SHIFT_CFG_W-1:0]  min_shift_reg, min_shift_next;
    logic [LIMIT_CFG_W-1:0]  item_limit_reg, item_limit_next;

    // item in flight
    logic [ACTION_W-1:0]     action_reg, action_next;
    logic [KEY_WIDTH-1:0]    key_reg, key_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [KEY_WIDTH-1:0]    perturb_reg, perturb_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        mask_reg, mask_next;

    // pending result and output beat
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [VALUE_WIDTH-1:0]  res_value_reg, res_value_next;
    logic [IDX_W-1:0]        res_slot_reg, res_slot_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [VALUE_WIDTH-1:0]  m_value_reg, m_value_next;
    logic [IDX_W-1:0]        m_slot_reg, m_slot_next;
    logic [CNT_W-1:0]        m_live_reg, m_live_next;

    // ram port
    logic                    ram_we, ram_re;
    logic [IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [WORD_W-1:0]       ram_wdata, ram_rdata;
    logic [TAG_W-1:0]        rd_tag;
    logic [KEY_WIDTH-1:0]    rd_key;
    logic [VALUE_WIDTH-1:0]  rd_val;

    // derived geometry and tests
    logic [SHIFT_W-1:0]      shift_ext, shift_eff;
    logic [CNT_W-1:0]        size_now;
    logic [IDX_W-1:0]        mask_now, home_idx, next_idx;
    logic [GROW_W-1:0]       used_plus_del;
    logic                    grow_fire, shrink_fire, limit_hit;
    logic                    is_store, tag_valid, key_eq, probe_last;
    logic                    walk_hit, walk_miss, start_walk;

    oaht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_tag = ram_rdata[WORD_W-1 -: TAG_W];
    assign rd_key = ram_rdata[VALUE_WIDTH +: KEY_WIDTH];
    assign rd_val = ram_rdata[VALUE_WIDTH-1:0];

    // table size in use, clamped to the ram depth
    assign shift_ext = SHIFT_W'(tbl_shift_reg);
    assign shift_eff = (shift_ext > SHIFT_W'(TABLE_SHIFT)) ? SHIFT_W'(TABLE_SHIFT) : shift_ext;
    assign size_now  = {{(CNT_W-1){1'b0}}, 1'b1} << shift_eff;
    assign mask_now  = IDX_W'(size_now - CNT_W'(1));
    assign home_idx  = IDX_W'(s_key) & mask_now;

    // grow, shrink and item limit tests
    assign used_plus_del = GROW_W'(used_reg) + GROW_W'(del_reg);
    assign grow_fire     = (used_plus_del + (used_plus_del >> 1)) >= GROW_W'(size_now);
    assign shrink_fire   = ((GROW_W'(used_reg) << 2) < GROW_W'(size_now)) &&
                           (shift_eff > SHIFT_W'(min_shift_reg));
    assign limit_hit     = (item_limit_reg != '0) &&
                           (LIM_CMP_W'(used_reg) >= LIM_CMP_W'(item_limit_reg));

    // probe step and slot checks
    assign next_idx   = ((idx_reg << 2) + idx_reg + IDX_W'(1) + IDX_W'(perturb_reg)) & mask_reg;
    assign is_store   = action_reg inside {ACT_INSERT, ACT_ADD};
    assign tag_valid  = (rd_tag == TAG_VALID);
    assign key_eq     = (rd_key == key_reg);
    assign probe_last = (probe_cnt_reg + PROBE_W'(1)) >= limit_reg;

    assign s_ready      = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_value_out  = m_value_reg;
    assign m_found_slot = m_slot_reg;
    assign m_live_count = m_live_reg;

    // next-state logic
    always_comb begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        sweep_report_next = sweep_report_reg;
        used_next         = used_reg;
        del_next          = del_reg;
        probe_cnt_next    = probe_cnt_reg;
        limit_next        = limit_reg;
        tbl_shift_next    = tbl_shift_reg;
        min_shift_next    = min_shift_reg;
        item_limit_next   = item_limit_reg;
        action_next       = action_reg;
        key_next          = key_reg;
        val_next          = val_reg;
        perturb_next      = perturb_reg;
        idx_next          = idx_reg;
        mask_next         = mask_reg;
        res_status_next   = res_status_reg;
        res_value_next    = res_value_reg;
        res_slot_next     = res_slot_reg;
        m_valid_next      = m_valid_reg;
        m_status_next     = m_status_reg;
        m_value_next      = m_value_reg;
        m_slot_next       = m_slot_reg;
        m_live_next       = m_live_reg;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg;
        ram_wdata         = ram_rdata;
        ram_re            = 1'b0;
        ram_raddr         = idx_reg;
        walk_hit          = 1'b0;
        walk_miss         = 1'b0;
        start_walk        = 1'b0;

        // configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TABLE_SHIFT: tbl_shift_next  = cfg_data[SHIFT_CFG_W-1:0];
                CFG_MIN_SHIFT:   min_shift_next  = cfg_data[SHIFT_CFG_W-1:0];
                CFG_ITEM_LIMIT:  item_limit_next = cfg_data[LIMIT_CFG_W-1:0];
                default: ;
            endcase
        end

        // output beat taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // mark every slot unused, one per cycle
            S_SWEEP: begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = {TAG_UNUSED, {(KEY_WIDTH + VALUE_WIDTH){1'b0}}};
                sweep_next = sweep_reg + IDX_W'(1);
                if (sweep_reg == {IDX_W{1'b1}}) begin
                    used_next = '0;
                    del_next  = '0;
                    if (sweep_report_reg) begin
                        res_status_next = STAT_OK;
                        res_value_next  = '0;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            // take an item, run the admission tests, read the home slot or start a clear
            S_IDLE: begin
                if (s_valid) begin
                    action_next    = s_action;
                    key_next       = s_key;
                    val_next       = s_operand_value;
                    res_value_next = '0;
                    res_slot_next  = '0;
                    case (s_action)
                        ACT_INSERT, ACT_ADD: begin
                            if (s_action == ACT_INSERT && limit_hit) begin
                                res_status_next = STAT_NO_SPACE;
                                state_next      = S_DONE;
                            end else if (grow_fire) begin
                                res_status_next = STAT_RESIZE;
                                state_next      = S_DONE;
                            end else begin
                                start_walk = 1'b1;
                            end
                        end
                        ACT_UPDATE, ACT_LOOKUP: begin
                            start_walk = 1'b1;
                        end
                        ACT_DELETE: begin
                            if (shrink_fire) begin
                                res_status_next = STAT_RESIZE;
                                state_next      = S_DONE;
                            end else begin
                                start_walk = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            sweep_next        = '0;
                            sweep_report_next = 1'b1;
                            state_next        = S_SWEEP;
                        end
                        default: begin
                            res_status_next = STAT_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                    endcase
                    if (start_walk) begin
                        ram_re         = 1'b1;
                        ram_raddr      = home_idx;
                        idx_next       = home_idx;
                        perturb_next   = s_key;
                        probe_cnt_next = '0;
                        limit_next     = PROBE_W'(size_now) + PROBE_W'(PERTURB_STEPS);
                        mask_next      = mask_now;
                        state_next     = S_WALK;
                    end
                end
            end

            // check one slot per cycle, read the next one on the chain
            S_WALK: begin
                case (action_reg)
                    ACT_INSERT, ACT_ADD: begin
                        if (!tag_valid) begin
                            walk_hit       = 1'b1;
                            ram_we         = 1'b1;
                            ram_wdata      = {TAG_VALID, key_reg, val_reg};
                            used_next      = used_reg + CNT_W'(1);
                            if (rd_tag == TAG_DELETED && del_reg != '0) begin
                                del_next = del_reg - CNT_W'(1);
                            end
                        end else if (key_eq) begin
                            walk_hit  = 1'b1;
                            ram_we    = 1'b1;
                            ram_wdata = {TAG_VALID, key_reg,
                                         (action_reg == ACT_ADD) ? rd_val + val_reg : val_reg};
                        end
                    end
                    ACT_UPDATE: begin
                        if (tag_valid && key_eq) begin
                            walk_hit  = 1'b1;
                            ram_we    = 1'b1;
                            ram_wdata = {TAG_VALID, key_reg, val_reg};
                        end
                    end
                    ACT_LOOKUP, ACT_DELETE: begin
                        if (rd_tag == TAG_UNUSED) begin
                            walk_miss = 1'b1;
                        end else if (tag_valid && key_eq) begin
                            walk_hit = 1'b1;
                            if (action_reg == ACT_LOOKUP) begin
                                res_value_next = rd_val;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = {TAG_DELETED, rd_key, rd_val};
                                del_next  = del_reg + CNT_W'(1);
                                if (used_reg != '0) begin
                                    used_next = used_reg - CNT_W'(1);
                                end
                            end
                        end
                    end
                    default: begin
                        walk_miss = 1'b1;
                    end
                endcase

                if (walk_hit) begin
                    res_status_next = STAT_OK;
                    res_slot_next   = idx_reg;
                    state_next      = S_DONE;
                end else if (walk_miss || probe_last) begin
                    res_status_next = is_store ? STAT_NO_SPACE : STAT_NOT_FOUND;
                    state_next      = S_DONE;
                end else begin
                    ram_re         = 1'b1;
                    ram_raddr      = next_idx;
                    idx_next       = next_idx;
                    perturb_next   = perturb_reg >> PROBE_SHIFT;
                    probe_cnt_next = probe_cnt_reg + PROBE_W'(1);
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_slot_next   = res_slot_reg;
                    m_live_next   = used_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_SWEEP;
            sweep_reg        <= '0;
            sweep_report_reg <= 1'b0;
            used_reg         <= '0;
            del_reg          <= '0;
            probe_cnt_reg    <= '0;
            limit_reg        <= '0;
            m_valid_reg      <= 1'b0;
            tbl_shift_reg    <= TABLE_SHIFT_RST;
            min_shift_reg    <= MIN_SHIFT_RST;
            item_limit_reg   <= ITEM_LIMIT_RST;
        end else begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            sweep_report_reg <= sweep_report_next;
            used_reg         <= used_next;
            del_reg          <= del_next;
            probe_cnt_reg    <= probe_cnt_next;
            limit_reg        <= limit_next;
            m_valid_reg      <= m_valid_next;
            tbl_shift_reg    <= tbl_shift_next;
            min_shift_reg    <= min_shift_next;
            item_limit_reg   <= item_limit_next;
        end
        action_reg     <= action_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        perturb_reg    <= perturb_next;
        idx_reg        <= idx_next;
        mask_reg       <= mask_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_slot_reg     <= m_slot_next;
        m_live_reg     <= m_live_next;
    end

    // a slot is never read and written in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn) !(ram_we && ram_re))
        else $error("slot ram read and write in the same cycle");

    // live entries never exceed the table depth
    assert property (@(posedge aclk) disable iff (!aresetn) used_reg <= CNT_W'(DEPTH))
        else $error("live entry count above table depth");

    // the walk never runs past its probe bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> probe_cnt_reg < limit_reg)
        else $error("probe walk ran past its bound");

    // an output beat only appears after a result was finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output beat raised without a finished result");

endmodule
